>>> hw/rtl/tle_pkg.sv
// Shared types and constants of the terminal line editor.
package tle_pkg;

  // Default and upper bound of the line length limit
  localparam int unsigned LineMaxDefault = 64;
  localparam int unsigned LineMaxHigh    = 64;

  // Line buffer banks: edit, previous, queued and emitting lines
  localparam int unsigned NumBanks = 4;
  localparam int unsigned BankW    = $clog2(NumBanks);

  // Character counts cover every limit up to LineMaxHigh
  localparam int unsigned CountW = $clog2(LineMaxHigh + 1);

  // Job queue depth between editor and emitter
  localparam int unsigned QueueDepth = 2;

  // Byte codes
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTilde     = 8'h7E;
  localparam logic [7:0] ChBang      = 8'h21;
  localparam logic [7:0] ChDollar    = 8'h24;

  // One finished line handed from editor to emitter
  typedef struct packed {
    logic [BankW-1:0]  bank;
    logic [CountW-1:0] len;
    logic              trunc;
    logic              recall;
  } tle_job_t;

endpackage

>>> hw/rtl/tle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, register the read entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tle_front.sv
// Line editor front end: takes raw bytes, edits the current line, queues finished lines.
module tle_front #(
  parameter int unsigned LINE_MAX = tle_pkg::LineMaxDefault
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_ready_o,
  input  logic [7:0]                                       in_byte_i,
  input  logic [tle_pkg::NumBanks-1:0]                     bank_busy_i,
  input  logic                                             q_full_i,
  output logic                                             push_o,
  output tle_pkg::tle_job_t                                job_o,
  output logic                                             wr_en_o,
  output logic [tle_pkg::BankW+$clog2(LINE_MAX)-1:0]       wr_addr_o,
  output logic [7:0]                                       wr_data_o
);
  import tle_pkg::*;

  localparam int unsigned IdxW  = $clog2(LINE_MAX);
  localparam int unsigned AddrW = BankW + IdxW;
  localparam int unsigned Depth = NumBanks << IdxW;

  localparam logic [CountW-1:0] CountLimit = CountW'(LINE_MAX - 2);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StDol2  = 2'd1;
  localparam logic [1:0] StBsChk = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] prev_count_q, prev_count_d;
  logic [BankW-1:0]  edit_bank_q, edit_bank_d;
  logic [BankW-1:0]  prev_bank_q, prev_bank_d;
  logic              discard_q, discard_d;
  logic              after_nl_q, after_nl_d;
  logic              first_bang_q, first_bang_d;

  logic              accept;
  logic              is_nl;
  logic              is_print;
  logic              finish;
  logic              finish_trunc;
  logic              recall;
  logic [BankW-1:0]  free_bank;
  logic [CountW-1:0] count_m1;
  logic [AddrW-1:0]  rd_addr;
  logic              rd_dollar;

  assign in_ready_o = (state_q == StIdle) && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_nl      = (in_byte_i == ChLf) || (in_byte_i == ChCr);
  assign is_print   = (in_byte_i >= ChSpace) && (in_byte_i <= ChTilde);
  assign count_m1   = count_q - CountW'(1);
  assign recall     = (count_q != '0) && first_bang_q;
  assign rd_addr    = {edit_bank_q, count_m1[IdxW-1:0]};

  // Pick the lowest bank that no line refers to after this finish
  always_comb begin
    free_bank = '0;
    for (int i = NumBanks - 1; i >= 0; i--) begin
      if (!bank_busy_i[i] && (BankW'(i) != edit_bank_q)) begin
        free_bank = BankW'(i);
      end
    end
  end

  // Dollar marks of stored characters, read back on backspace
  tle_ram #(
    .Width (1),
    .Depth (Depth)
  ) u_dollar_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_o),
    .waddr_i (wr_addr_o),
    .wdata_i (wr_data_o == ChDollar),
    .raddr_i (rd_addr),
    .rdata_o (rd_dollar)
  );

  // Edit the line one byte at a time
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    prev_count_d = prev_count_q;
    edit_bank_d  = edit_bank_q;
    prev_bank_d  = prev_bank_q;
    discard_d    = discard_q;
    after_nl_d   = after_nl_q;
    first_bang_d = first_bang_q;
    finish       = 1'b0;
    finish_trunc = 1'b0;
    wr_en_o      = 1'b0;
    wr_addr_o    = {edit_bank_q, count_q[IdxW-1:0]};
    wr_data_o    = in_byte_i;

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (is_nl) begin
            if (discard_q) begin
              discard_d  = 1'b0;
              after_nl_d = 1'b1;
            end else if (!after_nl_q) begin
              after_nl_d = 1'b1;
              finish     = 1'b1;
            end
          end else begin
            after_nl_d = 1'b0;
            if (!discard_q) begin
              if (count_q >= CountLimit) begin
                discard_d    = 1'b1;
                finish       = 1'b1;
                finish_trunc = 1'b1;
              end else if (in_byte_i == ChBackspace) begin
                if (count_q != '0) begin
                  count_d = count_m1;
                  state_d = StBsChk;
                end
              end else if (is_print) begin
                wr_en_o = 1'b1;
                count_d = count_q + CountW'(1);
                if (count_q == '0) begin
                  first_bang_d = (in_byte_i == ChBang);
                end
                if (in_byte_i == ChDollar) begin
                  state_d = StDol2;
                end
              end
            end
          end
        end
      end
      StDol2: begin
        // store the second character of a dollar pair
        wr_en_o   = 1'b1;
        wr_data_o = ChDollar;
        count_d   = count_q + CountW'(1);
        state_d   = StIdle;
      end
      StBsChk: begin
        // drop the other half of a dollar pair
        if (rd_dollar && (count_q != '0)) begin
          count_d = count_m1;
        end
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (finish) begin
      count_d = '0;
      if (!recall) begin
        prev_bank_d  = edit_bank_q;
        prev_count_d = count_q;
        edit_bank_d  = free_bank;
      end
    end
  end

  // Describe the finished line for the emitter
  always_comb begin
    push_o        = finish;
    job_o.bank    = recall ? prev_bank_q : edit_bank_q;
    job_o.len     = recall ? prev_count_q : count_q;
    job_o.trunc   = finish_trunc;
    job_o.recall  = recall;
  end

  // Hold editor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      prev_count_q <= '0;
      edit_bank_q  <= BankW'(0);
      prev_bank_q  <= BankW'(1);
      discard_q    <= 1'b0;
      after_nl_q   <= 1'b0;
      first_bang_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      prev_count_q <= prev_count_d;
      edit_bank_q  <= edit_bank_d;
      prev_bank_q  <= prev_bank_d;
      discard_q    <= discard_d;
      after_nl_q   <= after_nl_d;
      first_bang_q <= first_bang_d;
    end
  end

endmodule

>>> hw/rtl/tle_fifo.sv
// Short queue of finished-line jobs between editor and emitter.
module tle_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  tle_pkg::tle_job_t             job_i,
  input  logic                          pop_i,
  output tle_pkg::tle_job_t             head_o,
  output logic                          empty_o,
  output logic                          full_o,
  output logic [tle_pkg::NumBanks-1:0]  bank_busy_o
);
  import tle_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  tle_job_t          entry_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     fill_q;
  logic [QueueDepth-1:0] entry_valid;

  assign empty_o = (fill_q == '0);
  assign full_o  = (fill_q == (PtrW+1)'(QueueDepth));
  assign head_o  = entry_q[rd_ptr_q];

  // Mark entries between read and write pointer, and the banks they hold
  always_comb begin
    bank_busy_o = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      entry_valid[i] = (PtrW'(PtrW'(i) - rd_ptr_q) < fill_q[PtrW-1:0]) || full_o;
      if (entry_valid[i]) begin
        bank_busy_o[entry_q[i].bank] = 1'b1;
      end
    end
  end

  // Store a pushed job
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + (PtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

>>> hw/rtl/tle_back.sv
// Line emitter back end: reads a queued line out of the buffer, one character per transfer.
module tle_back #(
  parameter int unsigned LINE_MAX = tle_pkg::LineMaxDefault
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  tle_pkg::tle_job_t                           head_i,
  input  logic                                        empty_i,
  output logic                                        pop_o,
  output logic [tle_pkg::NumBanks-1:0]                bank_busy_o,
  output logic [tle_pkg::BankW+$clog2(LINE_MAX)-1:0]  rd_addr_o,
  input  logic [7:0]                                  rd_data_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [7:0]                                  out_char_o,
  output logic                                        out_has_o,
  output logic                                        out_last_o,
  output logic                                        out_trunc_o,
  output logic                                        out_recall_o
);
  import tle_pkg::*;

  localparam int unsigned IdxW = $clog2(LINE_MAX);

  tle_job_t          job_q;
  logic              active_q;
  logic [CountW-1:0] k_q;
  logic              pend_q;
  logic              pend_has_q, pend_last_q, pend_trunc_q, pend_recall_q;
  logic              out_valid_q;
  logic [7:0]        out_char_q;
  logic              out_has_q, out_last_q, out_trunc_q, out_recall_q;

  logic              issue;
  logic              is_last;

  assign pop_o     = !active_q && !empty_i;
  assign issue     = active_q && !pend_q && (!out_valid_q || out_ready_i);
  assign is_last   = (job_q.len == '0) || ((k_q + CountW'(1)) == job_q.len);
  assign rd_addr_o = {job_q.bank, k_q[IdxW-1:0]};

  // Flag the bank being read
  always_comb begin
    bank_busy_o = '0;
    if (active_q) begin
      bank_busy_o[job_q.bank] = 1'b1;
    end
  end

  // Take a job and walk its characters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      pend_q <= issue;
      if (pop_o) begin
        active_q <= 1'b1;
      end else if (issue && is_last) begin
        active_q <= 1'b0;
      end
    end
  end

  // Hold the job and the marks of the read in flight
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
      k_q   <= '0;
    end else if (issue) begin
      k_q <= k_q + CountW'(1);
    end
    if (issue) begin
      pend_has_q    <= (job_q.len != '0);
      pend_last_q   <= is_last;
      pend_trunc_q  <= job_q.trunc;
      pend_recall_q <= job_q.recall;
    end
  end

  // Load the output register when read data lands, drop it on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_char_q   <= pend_has_q ? rd_data_i : 8'h00;
      out_has_q    <= pend_has_q;
      out_last_q   <= pend_last_q;
      out_trunc_q  <= pend_trunc_q;
      out_recall_q <= pend_recall_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign out_has_o    = out_has_q;
  assign out_last_o   = out_last_q;
  assign out_trunc_o  = out_trunc_q;
  assign out_recall_o = out_recall_q;

endmodule

>>> hw/rtl/terminal_line_editor.sv
// Top level of the terminal line editor: editor, job queue, line buffer and emitter.
// Input: one byte per cycle; a stored '$' or an erasing backspace also holds the input.
// Output: after its newline or cut byte is taken, a finished line is queued and emitted;
// each character's registered line buffer read lands before another read is issued.
// Up to two finished lines wait in the job queue; a full queue holds the input.
// Reset (rst_ni low, asynchronous) empties the line, the previous line and the queue.
module terminal_line_editor #(
  parameter int unsigned LINE_MAX = tle_pkg::LineMaxDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,
  output logic [2:0] m_axis_tuser    // [0] has_char, [1] truncated, [2] recalled
);
  import tle_pkg::*;

  localparam int unsigned IdxW  = $clog2(LINE_MAX);
  localparam int unsigned AddrW = BankW + IdxW;
  localparam int unsigned Depth = NumBanks << IdxW;

  tle_job_t            push_job, head_job;
  logic                push, pop, q_empty, q_full;
  logic [NumBanks-1:0] q_busy, back_busy;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr, rd_addr;
  logic [7:0]          wr_data, rd_data;
  logic                has_char, trunc, recall;

  // Edit incoming bytes
  tle_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .bank_busy_i (q_busy | back_busy),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // Queue finished lines
  tle_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .empty_o     (q_empty),
    .full_o      (q_full),
    .bank_busy_o (q_busy)
  );

  // Line characters, banked by line
  tle_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Emit lines
  tle_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .bank_busy_o  (back_busy),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (m_axis_tdata),
    .out_has_o    (has_char),
    .out_last_o   (m_axis_tlast),
    .out_trunc_o  (trunc),
    .out_recall_o (recall)
  );

  assign m_axis_tuser = {recall, trunc, has_char};

endmodule

>>> hw/rtl/tle_checker.sv
// Port-level checks of the terminal line editor, bound to the top level.
module tle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [2:0] m_axis_tuser
);

  // An empty line carries a zero character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'h00))
    else $error("empty-line transfer with nonzero character");

  // An empty line is a single transfer, so it is the last one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("empty-line transfer without tlast");

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
       && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // Marks stay the same within one line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (!m_axis_tvalid || (m_axis_tuser[2:1] == $past(m_axis_tuser[2:1]))))
    else $error("line marks changed within a line");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
